### rtl/irf_pkg.sv
`default_nettype none
package irf_pkg;

    localparam int LETTER_W  = 8;
    localparam int THR_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_FILTER    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] letter_byte;
        logic       last_letter;
    } in_word_t;

    typedef struct packed {
        logic        kept;
        logic [5:0]  slot_index;
        logic [6:0]  kept_total;
        logic [15:0] dropped_total;
        logic [10:0] seq_length;
        logic        truncated;
        logic        store_full;
    } out_word_t;

    // letter word moving down the cell chain
    typedef struct packed {
        logic                vld;
        logic [LETTER_W-1:0] letter;
    } lane_t;

endpackage
`default_nettype wire

### rtl/irf_cell.sv
`default_nettype none
module irf_cell #(
    parameter int MAX_SEQS = 64,
    parameter int MAX_LEN  = 1024,
    parameter int CELL_ID  = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire irf_pkg::lane_t                    lane_in,
    input  wire logic [$clog2(MAX_LEN)-1:0]        pos_in,
    output irf_pkg::lane_t                         lane_out,
    output logic [$clog2(MAX_LEN)-1:0]             pos_out,
    input  wire logic [$clog2(MAX_SEQS+1)-1:0]     count,
    input  wire logic                              clr,
    input  wire logic                              len_we,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]      len_val,
    output logic [$clog2(MAX_LEN+1)-1:0]           match_cnt,
    output logic [$clog2(MAX_LEN+1)-1:0]           seq_len
);
    import irf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int POS_W  = $clog2(MAX_LEN+1);
    localparam int CNT_W  = $clog2(MAX_SEQS+1);
    localparam logic [CNT_W-1:0] MY_ID = CNT_W'(CELL_ID);

    logic [LETTER_W-1:0] mem [MAX_LEN];
    logic [LETTER_W-1:0] rd_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                chk_reg;
    logic                chk_next;
    logic [POS_W-1:0]    cnt_reg;
    logic [POS_W-1:0]    len_reg;
    lane_t               lane_reg;
    logic [ADDR_W-1:0]   pos_reg;
    logic                wr_sel;

    assign wr_sel   = (count == MY_ID);
    // only stored slots compare, and only within their own length
    assign chk_next = lane_in.vld && (MY_ID < count) && ({1'b0, pos_in} < len_reg);

    always_ff @(posedge clk)
    begin
        if (lane_in.vld && wr_sel)
        begin
            mem[pos_in] <= lane_in.letter;
        end
        rd_reg     <= mem[pos_in];
        letter_reg <= lane_in.letter;
        pos_reg    <= pos_in;
        if (len_we && wr_sel)
        begin
            len_reg <= len_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_reg  <= 1'b0;
            cnt_reg  <= '0;
            lane_reg <= '0;
        end
        else
        begin
            chk_reg  <= chk_next;
            lane_reg <= lane_in;
            if (clr)
            begin
                cnt_reg <= '0;
            end
            else if (chk_reg && (rd_reg == letter_reg))
            begin
                cnt_reg <= cnt_reg + POS_W'(1);
            end
        end
    end

    assign lane_out  = lane_reg;
    assign pos_out   = pos_reg;
    assign match_cnt = cnt_reg;
    assign seq_len   = len_reg;

endmodule
`default_nettype wire

### rtl/identity_redundancy_filter.sv
`default_nettype none
// Sequence redundancy filter. Letters enter one word per cycle and run down a chain of
// MAX_SEQS cells, one per stored slot, each holding its slot's letters and a match count.
// After the word with last_letter set, the input stalls while the chain drains, then,
// when filtering is on, for a select, multiply and compare step per stored slot of the
// identity check on a shared 17-bit by length multiplier (stopping at the first
// similar slot), then the result is posted. A result waiting on out_stall does not
// block letters of the next sequence; only the next end of sequence waits for it.
module identity_redundancy_filter #(
    parameter int MAX_SEQS = 64,
    parameter int MAX_LEN  = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire irf_pkg::in_word_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output irf_pkg::out_word_t                       out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [irf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [irf_pkg::THR_W-1:0]           cfg_data
);
    import irf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int POS_W  = $clog2(MAX_LEN+1);
    localparam int CNT_W  = $clog2(MAX_SEQS+1);
    localparam int SLOT_W = $clog2(MAX_SEQS);
    localparam int DR_W   = $clog2(MAX_SEQS+4);
    localparam int PROD_W = THR_W + POS_W;

    typedef enum logic [2:0] {
        ST_IN,
        ST_DRAIN,
        ST_SEL,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [THR_W-1:0]    thr_reg;
    logic                filt_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [15:0]         drop_reg;
    logic [DR_W-1:0]     drain_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [POS_W-1:0]    selcnt_reg;
    logic [POS_W-1:0]    minlen_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                sim_reg;
    logic [CNT_W-1:0]    slot_reg;
    logic                outv_reg;
    out_word_t           outd_reg;
    lane_t               inj_reg;
    logic [ADDR_W-1:0]   injpos_reg;

    lane_t               lane   [MAX_SEQS+1];
    logic [ADDR_W-1:0]   lpos   [MAX_SEQS+1];
    logic [POS_W-1:0]    cnt_w  [MAX_SEQS];
    logic [POS_W-1:0]    len_w  [MAX_SEQS];

    logic                in_acc;
    logic                done_go;
    logic                store_ok;
    logic [POS_W-1:0]    sel_len;
    logic [PROD_W-1:0]   lhs;
    logic [31:0]         kt_ext;
    logic [31:0]         sl_ext;
    logic [31:0]         ln_ext;
    logic [CNT_W-1:0]    res_slot;
    logic [CNT_W-1:0]    count_next;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IN);
    assign cfg_ready = 1'b1;
    assign done_go   = (state_reg == ST_DONE) && (!outv_reg || !out_stall);
    assign store_ok  = !sim_reg && (count_reg < CNT_W'(MAX_SEQS));
    assign sel_len   = len_w[scan_reg[SLOT_W-1:0]];
    assign lhs       = PROD_W'(selcnt_reg) << FRAC_W;

    assign lane[0] = inj_reg;
    assign lpos[0] = injpos_reg;

    for (genvar g = 0; g < MAX_SEQS; g++)
    begin : g_cell
        irf_cell #(
            .MAX_SEQS (MAX_SEQS),
            .MAX_LEN  (MAX_LEN),
            .CELL_ID  (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .lane_in   (lane[g]),
            .pos_in    (lpos[g]),
            .lane_out  (lane[g+1]),
            .pos_out   (lpos[g+1]),
            .count     (count_reg),
            .clr       (done_go),
            .len_we    (done_go && store_ok),
            .len_val   (pos_reg),
            .match_cnt (cnt_w[g]),
            .seq_len   (len_w[g])
        );
    end

    always_comb
    begin
        res_slot   = sim_reg ? slot_reg : (store_ok ? count_reg : '0);
        count_next = store_ok ? count_reg + CNT_W'(1) : count_reg;
        kt_ext     = 32'(count_next);
        sl_ext     = 32'(res_slot);
        ln_ext     = 32'(pos_reg);
    end

    always_ff @(posedge clk)
    begin
        injpos_reg <= pos_reg[ADDR_W-1:0];
        selcnt_reg <= cnt_w[scan_reg[SLOT_W-1:0]];
        minlen_reg <= (pos_reg < sel_len) ? pos_reg : sel_len;
        prod_reg   <= PROD_W'(thr_reg) * PROD_W'(minlen_reg);
        if (done_go)
        begin
            outd_reg.kept          <= store_ok;
            outd_reg.slot_index    <= sl_ext[5:0];
            outd_reg.kept_total    <= kt_ext[6:0];
            outd_reg.dropped_total <= (sim_reg && drop_reg != 16'hFFFF) ?
                                      drop_reg + 16'd1 : drop_reg;
            outd_reg.seq_length    <= ln_ext[10:0];
            outd_reg.truncated     <= ovf_reg;
            outd_reg.store_full    <= !sim_reg && !store_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IN;
            thr_reg     <= THR_W'(65536);
            filt_reg    <= 1'b1;
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
            count_reg   <= '0;
            drop_reg    <= '0;
            drain_reg   <= '0;
            scan_reg    <= '0;
            sim_reg     <= 1'b0;
            slot_reg    <= '0;
            outv_reg    <= 1'b0;
            inj_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_THRESHOLD: thr_reg  <= cfg_data;
                    REG_FILTER:    filt_reg <= cfg_data[0];
                    default:       ;
                endcase
            end
            if (outv_reg && !out_stall)
            begin
                outv_reg <= 1'b0;
            end
            inj_reg.letter <= in_data.letter_byte;
            inj_reg.vld <= 1'b0;
            unique case (state_reg)
                ST_IN:
                begin
                    if (in_acc)
                    begin
                        if (pos_reg < POS_W'(MAX_LEN))
                        begin
                            inj_reg.vld <= 1'b1;
                            pos_reg     <= pos_reg + POS_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (in_data.last_letter)
                        begin
                            drain_reg <= '0;
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + DR_W'(1);
                    if (drain_reg == DR_W'(MAX_SEQS+3))
                    begin
                        sim_reg   <= 1'b0;
                        scan_reg  <= '0;
                        state_reg <= (filt_reg && count_reg != '0) ? ST_SEL : ST_DONE;
                    end
                end
                ST_SEL:  state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_CMP;
                ST_CMP:
                begin
                    if (lhs >= prod_reg)
                    begin
                        sim_reg   <= 1'b1;
                        slot_reg  <= scan_reg;
                        state_reg <= ST_DONE;
                    end
                    else if (scan_reg + CNT_W'(1) == count_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + CNT_W'(1);
                        state_reg <= ST_SEL;
                    end
                end
                ST_DONE:
                begin
                    if (done_go)
                    begin
                        outv_reg  <= 1'b1;
                        count_reg <= count_next;
                        if (sim_reg && drop_reg != 16'hFFFF)
                        begin
                            drop_reg <= drop_reg + 16'd1;
                        end
                        pos_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_IN;
                    end
                end
                default: state_reg <= ST_IN;
            endcase
        end
    end

    assign out_valid = outv_reg;
    assign out_data  = outd_reg;

    a_kept_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.kept && out_data.store_full))
        else $error("kept word also flags a full store");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEQS))
        else $error("stored count past slot count");

    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done_go && store_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("stored count did not advance on a kept sequence");

    a_no_letter_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> !inj_reg.vld)
        else $error("letter entered the chain during the identity check");

endmodule
`default_nettype wire
